### rtl/minv_pkg.sv
package minv_pkg;

   localparam int MAX_DIM  = 4;
   localparam int MAT_N    = MAX_DIM * MAX_DIM;
   localparam int IDX_W    = 2;
   localparam int SIZE_W   = 3;
   localparam int E_W      = 12;
   localparam int FRAC_W   = 16;
   localparam int ACC_W    = 38;
   localparam int PROD_W   = 50;
   localparam int DET_W    = 50;
   localparam int INV_W    = 53;
   localparam int NUM_W    = ACC_W - 1 + FRAC_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W   = 6;
   localparam int TERM_W   = 3;
   localparam int N_TERMS  = 6;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;

   typedef enum logic [3:0] {
      S_LOAD,
      S_RA,
      S_RB,
      S_RC,
      S_MC,
      S_AC,
      S_CW,
      S_DR,
      S_DM,
      S_DA,
      S_DZ,
      S_SING,
      S_DV_INIT,
      S_DV_STEP,
      S_DV_OUT
   } state_type;

   typedef enum logic [1:0] {
      PROD_NONE,
      PROD_LOAD,
      PROD_MUL,
      PROD_DET
   } prod_op_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_CLR,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      DET_NONE,
      DET_CLR,
      DET_ADD
   } det_op_type;

   typedef struct packed {
      logic [SIZE_W-1:0] dim;
      logic              mem_we;
      logic [IDX_W-1:0]  wr_row;
      logic [IDX_W-1:0]  wr_col;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_row;
      logic [IDX_W-1:0]  rd_col;
      prod_op_type       prod_op;
      acc_op_type        acc_op;
      det_op_type        det_op;
      logic              cof_we;
      logic [3:0]        cof_idx;
      logic [3:0]        cof_rd_idx;
      logic              div_init;
      logic              div_step;
      logic              out_load;
      logic              out_singular;
      logic [IDX_W-1:0]  out_row;
      logic [IDX_W-1:0]  out_col;
      logic              out_last;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic out_busy;
   } sts_type;

   // Index of the k-th remaining row or column once row or column skip is removed.
   function automatic logic [IDX_W-1:0] minor_idx(input logic [IDX_W-1:0] k,
                                                  input logic [IDX_W-1:0] skip);
      minor_idx = (k < skip) ? k : IDX_W'(k + 2'd1);
   endfunction

   // Column position taken by row position pos in permutation t of three.
   function automatic logic [IDX_W-1:0] perm_col(input logic [TERM_W-1:0] t,
                                                 input logic [IDX_W-1:0] pos);
      logic [5:0] p;
      case (t)
         3'd0:    p = {2'd2, 2'd1, 2'd0};
         3'd1:    p = {2'd1, 2'd2, 2'd0};
         3'd2:    p = {2'd2, 2'd0, 2'd1};
         3'd3:    p = {2'd0, 2'd2, 2'd1};
         3'd4:    p = {2'd1, 2'd0, 2'd2};
         3'd5:    p = {2'd0, 2'd1, 2'd2};
         default: p = {2'd2, 2'd1, 2'd0};
      endcase
      case (pos)
         2'd0:    perm_col = p[1:0];
         2'd1:    perm_col = p[3:2];
         default: perm_col = p[5:4];
      endcase
   endfunction

   function automatic logic perm_odd(input logic [TERM_W-1:0] t);
      case (t)
         3'd1, 3'd2, 3'd5: perm_odd = 1'b1;
         default:          perm_odd = 1'b0;
      endcase
   endfunction

endpackage

### rtl/minv_if.sv
interface minv_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [minv_pkg::E_W-1:0]     entry_value;
   modport source (output valid, output entry_value, input ready);
   modport sink   (input valid, input entry_value, output ready);
endinterface

interface minv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [minv_pkg::IDX_W-1:0]          row_index;
   logic [minv_pkg::IDX_W-1:0]          col_index;
   logic signed [minv_pkg::INV_W-1:0]   inverse_value;
   logic signed [minv_pkg::DET_W-1:0]   det_value;
   logic                                singular;
   logic                                last;
   modport source (output valid, output row_index, output col_index, output inverse_value,
                   output det_value, output singular, output last, input ready);
   modport sink   (input valid, input row_index, input col_index, input inverse_value,
                   input det_value, input singular, input last, output ready);
endinterface

interface minv_csr_if;
   logic                                valid;
   logic                                ready;
   logic [minv_pkg::SIZE_W-1:0]         size_in_use;
   modport source (output valid, output size_in_use, input ready);
   modport sink   (input valid, input size_in_use, output ready);
endinterface

### rtl/matrix_inverse_adjugate_unit.sv
// Matrix inverse by adjugate. Requests carry one signed 12-bit entry each, in row-major
// order, for a square matrix of the size held in the size register (written on the csr
// channel; 0 acts as 1, above 4 acts as 4; a write restarts the load). The size register
// accepts writes only while loading, and a write wins over a request in the same cycle.
// Entries are taken one per cycle while loading, unless a size write is offered. After
// the last entry, the matrix is padded to 4x4 with the identity and all sixteen signed
// 3x3 minors are formed on one shared multiply-accumulate path, each as six triple
// products followed by a store. The determinant is then formed along the first row and
// tested for zero. A zero determinant gives one result marked singular. Else each of
// the n*n inverse entries, adjugate times 2^16 over the determinant truncated toward
// zero, comes from a restoring divider at one quotient bit a cycle. No request is taken
// until the run's last result is in the output register; that register then waits on
// its own for the consumer.
module matrix_inverse_adjugate_unit (
   input  logic        clock,
   input  logic        reset,
   minv_req_if.sink    req_chan,
   minv_rsp_if.source  rsp_chan,
   minv_csr_if.sink    csr_chan
);
   import minv_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   // The controller sequences loading, cofactors, determinant and division.
   minv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .csr_chan  (csr_chan),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the store, the arithmetic and the output register.
   minv_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .entry_value (req_chan.entry_value),
      .sts         (sts),
      .rsp_chan    (rsp_chan)
   );

   assign req_chan.ready = req_ready;

endmodule

### rtl/minv_dp.sv
module minv_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  minv_pkg::cmd_type               cmd,
   input  logic signed [minv_pkg::E_W-1:0] entry_value,
   output minv_pkg::sts_type               sts,
   minv_rsp_if.source                      rsp_chan
);
   import minv_pkg::*;

   logic signed [E_W-1:0]    mem [MAT_N];
   logic signed [E_W-1:0]    mem_q_ff;
   logic                     pad_ff;
   logic                     diag_ff;
   logic signed [E_W-1:0]    rd_val;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic signed [ACC_W-1:0]  cof_ff [MAT_N];
   logic signed [ACC_W-1:0]  cof_rd;
   logic signed [47:0]       mul3;
   logic signed [PROD_W-1:0] mul_det;
   logic [ACC_W-1:0]         mag_c;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DET_W-1:0]         rem_ff, rem_in;
   logic [DET_W-1:0]         dvs_ff, dvs_in;
   logic                     sgn_ff, sgn_in;
   logic [DET_W:0]           sh;
   logic [DET_W:0]           diff;
   logic                     ge;
   logic                     valid_ff, valid_in;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic signed [INV_W-1:0]  inv_ff;
   logic signed [DET_W-1:0]  dout_ff;
   logic                     sing_ff, last_ff;

   // Matrix store; rows and columns beyond the size read as the identity.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[{cmd.wr_row, cmd.wr_col}] <= entry_value;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[{cmd.rd_row, cmd.rd_col}];
         pad_ff   <= ({1'b0, cmd.rd_row} >= cmd.dim) || ({1'b0, cmd.rd_col} >= cmd.dim);
         diag_ff  <= (cmd.rd_row == cmd.rd_col);
      end
   end

   assign rd_val  = pad_ff ? (diag_ff ? E_W'(1) : '0) : mem_q_ff;
   assign cof_rd  = cof_ff[cmd.cof_rd_idx];
   assign mul3    = $signed(prod_ff[35:0]) * rd_val;
   assign mul_det = cof_rd * rd_val;

   always_comb begin
      case (cmd.prod_op)
         PROD_LOAD: prod_in = PROD_W'(rd_val);
         PROD_MUL:  prod_in = PROD_W'(mul3);
         PROD_DET:  prod_in = mul_det;
         default:   prod_in = prod_ff;
      endcase
      case (cmd.acc_op)
         ACC_CLR: acc_in = '0;
         ACC_ADD: acc_in = acc_ff + $signed(prod_ff[ACC_W-1:0]);
         ACC_SUB: acc_in = acc_ff - $signed(prod_ff[ACC_W-1:0]);
         default: acc_in = acc_ff;
      endcase
      case (cmd.det_op)
         DET_CLR: det_in = '0;
         DET_ADD: det_in = det_ff + prod_ff;
         default: det_in = det_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      det_ff  <= det_in;
      if (cmd.cof_we) begin
         cof_ff[cmd.cof_idx] <= acc_ff;
      end
   end

   // Restoring divider, one quotient bit a cycle on magnitudes.
   always_comb begin
      mag_c  = cof_rd[ACC_W-1] ? ACC_W'(-cof_rd) : ACC_W'(cof_rd);
      sh     = {rem_ff, num_ff[NUM_W-1]};
      diff   = sh - {1'b0, dvs_ff};
      ge     = (sh >= {1'b0, dvs_ff});
      num_in = num_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      sgn_in = sgn_ff;
      if (cmd.div_init) begin
         num_in = {mag_c[ACC_W-2:0], {FRAC_W{1'b0}}};
         rem_in = '0;
         dvs_in = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
         sgn_in = cof_rd[ACC_W-1] ^ det_ff[DET_W-1];
      end else if (cmd.div_step) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DET_W-1:0] : sh[DET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sgn_ff <= sgn_in;
   end

   // Output register.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         row_ff  <= cmd.out_row;
         col_ff  <= cmd.out_col;
         sing_ff <= cmd.out_singular;
         last_ff <= cmd.out_last;
         dout_ff <= cmd.out_singular ? '0 : det_ff;
         if (cmd.out_singular) begin
            inv_ff <= '0;
         end else if (sgn_ff) begin
            inv_ff <= INV_W'(-num_ff);
         end else begin
            inv_ff <= INV_W'(num_ff);
         end
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.row_index     = row_ff;
   assign rsp_chan.col_index     = col_ff;
   assign rsp_chan.inverse_value = inv_ff;
   assign rsp_chan.det_value     = dout_ff;
   assign rsp_chan.singular      = sing_ff;
   assign rsp_chan.last          = last_ff;

   assign sts.det_zero = (det_ff == '0);
   assign sts.out_busy = valid_ff & ~rsp_chan.ready;

`ifndef SYNTHESIS
   // A new result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_busy)
      else $error("result loaded while output register held");

   // A singular result always carries a zero determinant.
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.out_singular |=> rsp_chan.det_value == '0)
      else $error("singular result with nonzero determinant");

   // The divider is never started on a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |=> dvs_ff != '0)
      else $error("division started with zero determinant");
`endif

endmodule

### rtl/minv_ctrl.sv
module minv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   minv_csr_if.sink           csr_chan,
   input  minv_pkg::sts_type  sts,
   output minv_pkg::cmd_type  cmd
);
   import minv_pkg::*;

   state_type            state_ff, state_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [SIZE_W-1:0]    dim;
   logic [IDX_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0]     p_ff, p_in, q_ff, q_in;
   logic [TERM_W-1:0]    t_ff, t_in;
   logic [STEP_W-1:0]    k_ff, k_in;
   logic                 col_end, row_end;
   logic                 csr_ready;

   // The size register is only written while loading, never under a run.
   assign csr_ready      = (state_ff == S_LOAD);
   assign csr_chan.ready = csr_ready;
   assign dim = (size_ff == '0) ? SIZE_W'(1) :
                (size_ff > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_ff;
   assign col_end = (({1'b0, col_ff} + 3'd1) == dim);
   assign row_end = (({1'b0, row_ff} + 3'd1) == dim);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         size_ff  <= SIZE_RESET;
         row_ff   <= '0;
         col_ff   <= '0;
         p_ff     <= '0;
         q_ff     <= '0;
         t_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         p_ff     <= p_in;
         q_ff     <= q_in;
         t_ff     <= t_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      size_in   = size_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.dim   = dim;

      if (csr_chan.valid && csr_ready) begin
         size_in = csr_chan.size_in_use;
         row_in  = '0;
         col_in  = '0;
      end

      case (state_ff)
         S_LOAD: begin
            // A size write in the same cycle restarts the load, so the request waits.
            req_ready  = !csr_chan.valid;
            cmd.wr_row = row_ff;
            cmd.wr_col = col_ff;
            if (req_valid && !csr_chan.valid) begin
               cmd.mem_we = 1'b1;
               if (col_end) begin
                  col_in = '0;
                  if (row_end) begin
                     row_in     = '0;
                     p_in       = '0;
                     q_in       = '0;
                     t_in       = '0;
                     cmd.acc_op = ACC_CLR;
                     cmd.det_op = DET_CLR;
                     state_in   = S_RA;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         S_RA: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_row = minor_idx(2'd0, p_ff);
            cmd.rd_col = minor_idx(perm_col(t_ff, 2'd0), q_ff);
            state_in   = S_RB;
         end
         S_RB: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_row  = minor_idx(2'd1, p_ff);
            cmd.rd_col  = minor_idx(perm_col(t_ff, 2'd1), q_ff);
            cmd.prod_op = PROD_LOAD;
            state_in    = S_RC;
         end
         S_RC: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_row  = minor_idx(2'd2, p_ff);
            cmd.rd_col  = minor_idx(perm_col(t_ff, 2'd2), q_ff);
            cmd.prod_op = PROD_MUL;
            state_in    = S_MC;
         end
         S_MC: begin
            cmd.prod_op = PROD_MUL;
            state_in    = S_AC;
         end
         S_AC: begin
            cmd.acc_op = (perm_odd(t_ff) ^ p_ff[0] ^ q_ff[0]) ? ACC_SUB : ACC_ADD;
            if (t_ff == TERM_W'(N_TERMS - 1)) begin
               t_in     = '0;
               state_in = S_CW;
            end else begin
               t_in     = t_ff + 3'd1;
               state_in = S_RA;
            end
         end
         S_CW: begin
            cmd.cof_we  = 1'b1;
            cmd.cof_idx = {p_ff, q_ff};
            cmd.acc_op  = ACC_CLR;
            state_in    = S_RA;
            if (q_ff == IDX_W'(MAX_DIM - 1)) begin
               q_in = '0;
               if (p_ff == IDX_W'(MAX_DIM - 1)) begin
                  p_in     = '0;
                  col_in   = '0;
                  state_in = S_DR;
               end else begin
                  p_in = p_ff + 2'd1;
               end
            end else begin
               q_in = q_ff + 2'd1;
            end
         end
         S_DR: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_row = '0;
            cmd.rd_col = col_ff;
            state_in   = S_DM;
         end
         S_DM: begin
            cmd.cof_rd_idx = {2'd0, col_ff};
            cmd.prod_op    = PROD_DET;
            state_in       = S_DA;
         end
         S_DA: begin
            cmd.det_op = DET_ADD;
            if (col_ff == IDX_W'(MAX_DIM - 1)) begin
               col_in   = '0;
               state_in = S_DZ;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = S_DR;
            end
         end
         S_DZ: begin
            row_in   = '0;
            col_in   = '0;
            state_in = sts.det_zero ? S_SING : S_DV_INIT;
         end
         S_SING: begin
            if (!sts.out_busy) begin
               cmd.out_load     = 1'b1;
               cmd.out_singular = 1'b1;
               cmd.out_last     = 1'b1;
               state_in         = S_LOAD;
            end
         end
         S_DV_INIT: begin
            // The adjugate is the transposed cofactor matrix.
            cmd.cof_rd_idx = {col_ff, row_ff};
            cmd.div_init   = 1'b1;
            k_in           = '0;
            state_in       = S_DV_STEP;
         end
         S_DV_STEP: begin
            cmd.div_step = 1'b1;
            k_in         = k_ff + 6'd1;
            if (k_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DV_OUT;
            end
         end
         S_DV_OUT: begin
            cmd.out_row  = row_ff;
            cmd.out_col  = col_ff;
            cmd.out_last = row_end & col_end;
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_DV_INIT;
               if (col_end) begin
                  col_in = '0;
                  if (row_end) begin
                     row_in   = '0;
                     state_in = S_LOAD;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

`ifndef SYNTHESIS
   // Entries are written to the store only while loading.
   a_we_load: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> state_ff == S_LOAD)
      else $error("store written outside the load phase");

   // A zero determinant leads straight to the singular result.
   a_zero_sing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DZ && sts.det_zero |=> state_ff == S_SING)
      else $error("zero determinant did not yield singular result");

   // The final result of a run returns the block to loading.
   a_last_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.out_last |=> state_ff == S_LOAD)
      else $error("final result did not end the run");
`endif

endmodule

### tb/sv/matrix_inverse_adjugate_unit_tb.sv
module matrix_inverse_adjugate_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import minv_pkg::*;

   typedef longint mat_type [MAT_N];

   // One inverse entry as the block should report it.
   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [INV_W-1:0] inv;
      logic signed [DET_W-1:0] det;
      logic                    sing;
      logic                    last;
   } inv_entry_type;

   localparam int CYCLE_LIMIT = 1000000;
   // A run ends once its last result is out, so this margin comfortably covers
   // any leftover work once the final result is taken.
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   minv_req_if req_chan ();
   minv_rsp_if rsp_chan ();
   minv_csr_if csr_chan ();

   matrix_inverse_adjugate_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: loaded entries, load position and size register.
   mat_type          shadow_mat;
   int               shadow_count;
   logic [SIZE_W-1:0] shadow_size;
   inv_entry_type    pending_inverse [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int request_count = 0;
   int result_count = 0;
   int matrix_count = 0;
   int singular_count = 0;
   int cycle_count = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.entry_value = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.size_in_use = '0;
      shadow_mat = '{default: 0};
      shadow_count = 0;
      shadow_size = SIZE_RESET;
   end

   // Copy of m without row p and column q, both on a stride of MAX_DIM.
   function automatic mat_type strike_out(input mat_type m, input int n, input int p,
                                          input int q);
      mat_type s;
      int   i;
      int   j;
      s = '{default: 0};
      i = 0;
      for (int r = 0; r < n; r++) begin
         if (r != p) begin
            j = 0;
            for (int c = 0; c < n; c++) begin
               if (c != q) begin
                  s[i*MAX_DIM + j] = m[r*MAX_DIM + c];
                  j++;
               end
            end
            i++;
         end
      end
      return s;
   endfunction

   // Determinant by expansion along the first row; exact in 64 bits at these sizes.
   function automatic longint cofactor_det(input mat_type m, input int n);
      longint d;
      longint t;
      d = 0;
      if (n == 1) return m[0];
      for (int f = 0; f < n; f++) begin
         t = m[f] * cofactor_det(strike_out(m, n, 0, f), n - 1);
         if (f % 2 == 1) d -= t;
         else d += t;
      end
      return d;
   endfunction

   function automatic int active_dim();
      if (shadow_size == 0) return 1;
      if (shadow_size > MAX_DIM) return MAX_DIM;
      return int'(shadow_size);
   endfunction

   // Takes one accepted request and, if it completes the matrix, queues the
   // inverse entries (or the singular marker) that the block must produce.
   task automatic absorb_entry(input logic signed [E_W-1:0] v);
      int            n;
      int            total;
      int            idx;
      longint        d;
      longint        adj;
      inv_entry_type e;
      n = active_dim();
      total = n * n;
      idx = shadow_count;
      if (idx >= total) idx = 0;
      shadow_mat[(idx / n)*MAX_DIM + (idx % n)] = longint'(v);
      idx++;
      if (idx < total) begin
         shadow_count = idx;
         return;
      end
      shadow_count = 0;
      matrix_count++;
      d = cofactor_det(shadow_mat, n);
      if (d == 0) begin
         singular_count++;
         e = '{row: '0, col: '0, inv: '0, det: '0, sing: 1'b1, last: 1'b1};
         pending_inverse = {pending_inverse, e};
         return;
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (n == 1) begin
               adj = 1;
            end else begin
               adj = cofactor_det(strike_out(shadow_mat, n, j, i), n - 1);
               if ((i + j) % 2 == 1) adj = -adj;
            end
            // Division of longint truncates toward zero, as the fixed point needs.
            e.row = IDX_W'(i);
            e.col = IDX_W'(j);
            e.inv = INV_W'((adj * 65536) / d);
            e.det = DET_W'(d);
            e.sing = 1'b0;
            e.last = (i == n - 1 && j == n - 1);
            pending_inverse = {pending_inverse, e};
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // The consumer stalls at random according to recv_stall_pct.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Each result taken by the consumer is checked against the oldest expected entry.
   always @(posedge clock) begin
      inv_entry_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         if (pending_inverse.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
         end else begin
            e = pending_inverse.pop_front();
            if (rsp_chan.row_index !== e.row)
               report_mismatch($sformatf("row_index %0d, want %0d", rsp_chan.row_index, e.row));
            if (rsp_chan.col_index !== e.col)
               report_mismatch($sformatf("col_index %0d, want %0d", rsp_chan.col_index, e.col));
            if (rsp_chan.inverse_value !== e.inv)
               report_mismatch($sformatf("inverse_value %0d, want %0d (row %0d col %0d)",
                                         rsp_chan.inverse_value, e.inv, e.row, e.col));
            if (rsp_chan.det_value !== e.det)
               report_mismatch($sformatf("det_value %0d, want %0d",
                                         rsp_chan.det_value, e.det));
            if (rsp_chan.singular !== e.sing)
               report_mismatch($sformatf("singular %0b, want %0b", rsp_chan.singular, e.sing));
            if (rsp_chan.last !== e.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_chan.last, e.last));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_inverse.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Sends one request, idling first at random, and feeds the shadow once it is taken.
   task automatic send_entry(input logic signed [E_W-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.entry_value <= v;
      do @(posedge clock); while (!req_chan.ready);
      request_count++;
      absorb_entry(v);
   endtask

   // Drops the request valid and waits until every expected result is in,
   // plus a margin so the block is truly back at rest.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_inverse.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the size register; a write also restarts any partial load.
   task automatic write_size(input logic [SIZE_W-1:0] s);
      req_chan.valid <= 1'b0;
      csr_chan.valid <= 1'b1;
      csr_chan.size_in_use <= s;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      shadow_size = s;
      shadow_count = 0;
   endtask

   function automatic logic signed [E_W-1:0] random_entry();
      case ($urandom_range(9))
         0:       return -12'sd2048;
         1:       return 12'sd2047;
         2, 3:    return E_W'($signed($urandom_range(6)) - 3);
         default: return E_W'($urandom);
      endcase
   endfunction

   // 1x1 matrices at the field extremes, a zero entry that is singular, and the
   // size codes 0 and 7 that clamp to 1 and 4.
   task automatic test_extremes_and_clamping();
      write_size(3'd1);
      send_entry(12'sd2047);
      send_entry(-12'sd2048);
      send_entry(12'sd1);
      send_entry(12'sd0);
      drain_results();
      write_size(3'd0);
      send_entry(-12'sd1);
      drain_results();
      write_size(3'd7);
      for (int k = 0; k < MAT_N; k++) send_entry((k % 5 == 0) ? 12'sd2047 : -12'sd2048);
      drain_results();
   endtask

   // A 2x2 singular matrix and a load cut short by a size write.
   task automatic test_singular_and_restart();
      write_size(3'd2);
      send_entry(12'sd3);
      send_entry(-12'sd6);
      send_entry(-12'sd1);
      send_entry(12'sd2);
      drain_results();
      write_size(3'd3);
      send_entry(12'sd5);
      send_entry(12'sd9);
      write_size(3'd2);
      send_entry(12'sd4);
      send_entry(12'sd7);
      send_entry(12'sd2);
      send_entry(12'sd6);
      drain_results();
   endtask

   // Random matrices of random size, a share of them singular by a repeated row,
   // and now and then a load broken off by a size write.
   task automatic test_random_matrices(input int item_budget);
      int             n;
      int             pick;
      int             sent;
      int             cut;
      logic [SIZE_W-1:0] code;
      logic signed [E_W-1:0] row0 [MAX_DIM];
      logic signed [E_W-1:0] v;
      sent = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(99);
         n = (pick < 10) ? 1 : (pick < 45) ? 2 : (pick < 80) ? 3 : 4;
         code = SIZE_W'(n);
         if (n == 1 && $urandom_range(3) == 0) code = 3'd0;
         if (n == 4 && $urandom_range(3) == 0) code = SIZE_W'($urandom_range(5, 7));
         write_size(code);
         if ($urandom_range(19) == 0) begin
            cut = $urandom_range(1, n * n);
            for (int k = 0; k < cut - 1; k++) begin
               send_entry(random_entry());
               sent++;
            end
            if (cut > 1) begin
               drain_results();
               write_size(code);
            end
         end
         pick = $urandom_range(99);
         for (int k = 0; k < n * n; k++) begin
            v = random_entry();
            if (k < n) row0[k] = v;
            if (n > 1 && pick < 15 && k >= n && k < 2 * n) v = row0[k - n];
            send_entry(v);
            sent++;
         end
         drain_results();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes_and_clamping();
      test_singular_and_restart();
      send_idle_pct = 33;
      recv_stall_pct = 73;
      test_random_matrices(66);
      send_idle_pct = 73;
      recv_stall_pct = 33;
      test_random_matrices(66);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_matrices(66);
      drain_results();
      $display("covered %0d requests, %0d matrices (%0d singular), %0d results checked",
               request_count, matrix_count, singular_count, result_count);
      $display("sizes 1 to 4 with clamped codes, load restarts and three idle patterns");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
